FILE: design/swrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_pkg - shared types and constants for the sliding window rate meter
// Widths, window size, item classification and the back end state encoding.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int WINDOW   = 64;
    localparam int TIME_W   = 48;
    localparam int PKT_W    = 16;
    localparam int OFS_W    = 8;
    localparam int SIZE_W   = 17;
    localparam int RATE_W   = 56;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int PTR_W    = $clog2(WINDOW);
    localparam int MAX_SIZE = ((1 << PKT_W) - 1) + ((1 << OFS_W) - 1);
    localparam int SUM_W    = $clog2((WINDOW - 1) * MAX_SIZE + 1);

    // bits per byte times nanoseconds per second
    localparam int SCALE_W = 33;
    localparam logic [SCALE_W-1:0] BITS_NS_SCALE = 33'd8000000000;

    localparam int DVD_W = SUM_W + SCALE_W;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int SAT_W = (DVD_W > RATE_W) ? DVD_W : RATE_W;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        K_FIRST,
        K_APPEND,
        K_IGNORE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TIME_W-1:0]  now;
        logic [SIZE_W-1:0]  size;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_EVICT,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } t_back_state;

    // ring index ptr + k, wrapped at the window size (ptr < WINDOW, k <= WINDOW)
    function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [FILL_W-1:0] k);
        logic [FILL_W:0] s;
        s = (FILL_W + 1)'(ptr) + (FILL_W + 1)'(k);
        if (s >= (FILL_W + 1)'(WINDOW)) begin
            s = s - (FILL_W + 1)'(WINDOW);
        end
        return PTR_W'(s);
    endfunction

endpackage

FILE: design/sliding_window_rate_meter.sv
`timescale 1ns / 1ps
// With the back end idle, a first or ignored item goes through the apply and output states;
// an update also goes through the multiply, divider start and divider wait states, and a
// full window adds the evict state after apply.
// The back end handles one item at a time and an update waits on the bit serial divider;
// the queue holds further items meanwhile and stalls the input when it is full.
// Reset: synchronous, active low; clears fill, sums, rate and queue; rings are not cleared.
// ----------------------------------------------------------------------------
// sliding_window_rate_meter - throughput estimate over the last packet events
// Front classifies items, a short queue decouples it from the back end that
// maintains the window and divides the byte count by the time span.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [swrm_pkg::TIME_W-1:0]   i_now_ns,
    input  logic [swrm_pkg::PKT_W-1:0]    i_pkt_size,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [swrm_pkg::RATE_W-1:0]   o_rate_bps,
    output logic                          o_rate_updated,
    output logic [swrm_pkg::FILL_W-1:0]   o_window_fill,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swrm_pkg::OFS_W-1:0]    i_cfg_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    swrm_pkg::t_item f_item;
    swrm_pkg::t_item q_item;

    assign o_stall     = q_full;
    assign o_cfg_ready = 1'b1;

    swrm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_now_ns    (i_now_ns),
        .i_pkt_size  (i_pkt_size),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_item      (f_item)
    );

    swrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    swrm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rate_bps     (o_rate_bps),
        .o_rate_updated (o_rate_updated),
        .o_window_fill  (o_window_fill)
    );

endmodule

FILE: design/swrm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_ram - generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/swrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_front - item intake and classification
// Adds the size offset, tracks the newest accepted time and tags each item
// as first, append or ignore before it enters the queue.
// ----------------------------------------------------------------------------
module swrm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [swrm_pkg::TIME_W-1:0]   i_now_ns,
    input  logic [swrm_pkg::PKT_W-1:0]    i_pkt_size,
    input  logic                          i_cfg_valid,
    input  logic [swrm_pkg::OFS_W-1:0]    i_cfg_data,
    input  logic                          i_full,
    output logic                          o_push,
    output swrm_pkg::t_item               o_item
);

    logic [swrm_pkg::OFS_W-1:0]  r_size_offset;
    logic                        r_have;
    logic [swrm_pkg::TIME_W-1:0] r_newest;
    swrm_pkg::t_kind             kind;

    always_comb begin
        if (!r_have) begin
            kind = swrm_pkg::K_FIRST;
        end else if (i_now_ns > r_newest) begin
            kind = swrm_pkg::K_APPEND;
        end else begin
            kind = swrm_pkg::K_IGNORE;
        end
        o_item.kind = kind;
        o_item.now  = i_now_ns;
        o_item.size = swrm_pkg::SIZE_W'(i_pkt_size) + swrm_pkg::SIZE_W'(r_size_offset);
    end

    assign o_push = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_offset <= '0;
            r_have        <= 1'b0;
            r_newest      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_size_offset <= i_cfg_data;
            end
            // advance the newest time only for items that enter the window
            if (o_push && kind != swrm_pkg::K_IGNORE) begin
                r_have   <= 1'b1;
                r_newest <= i_now_ns;
            end
        end
    end

endmodule

FILE: design/swrm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_queue - short item queue between front and back
// Register based FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module swrm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swrm_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output swrm_pkg::t_item o_item
);

    swrm_pkg::t_item                r_mem [swrm_pkg::QDEPTH];
    logic [swrm_pkg::QPTR_W-1:0]    r_wr;
    logic [swrm_pkg::QPTR_W-1:0]    r_rd;
    logic [swrm_pkg::QCNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == swrm_pkg::QCNT_W'(swrm_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == swrm_pkg::QPTR_W'(swrm_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == swrm_pkg::QPTR_W'(swrm_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: design/swrm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_div - bit serial restoring divider
// One quotient bit per cycle; quotient bits shift into the dividend register.
// ----------------------------------------------------------------------------
module swrm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swrm_pkg::DVD_W-1:0]    i_dividend,
    input  logic [swrm_pkg::TIME_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [swrm_pkg::DVD_W-1:0]    o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [swrm_pkg::CNT_W-1:0]   r_cnt;
    logic [swrm_pkg::DVD_W-1:0]   r_dvd;
    logic [swrm_pkg::TIME_W-1:0]  r_dsr;
    logic [swrm_pkg::TIME_W-1:0]  r_rem;
    logic [swrm_pkg::TIME_W:0]    rem_sh;
    logic [swrm_pkg::TIME_W:0]    diff;
    logic                         q_bit;

    always_comb begin
        rem_sh = {r_rem, r_dvd[swrm_pkg::DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        q_bit  = !diff[swrm_pkg::TIME_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[swrm_pkg::DVD_W-2:0], q_bit};
            r_rem <= q_bit ? diff[swrm_pkg::TIME_W-1:0] : rem_sh[swrm_pkg::TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= swrm_pkg::CNT_W'(swrm_pkg::DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == swrm_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

FILE: design/swrm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrm_back - window update and rate computation
// Keeps the time and size rings, the running byte sum and the rate, runs the
// divider and drives the result register.
// ----------------------------------------------------------------------------
module swrm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  swrm_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [swrm_pkg::RATE_W-1:0]   o_rate_bps,
    output logic                          o_rate_updated,
    output logic [swrm_pkg::FILL_W-1:0]   o_window_fill
);

    swrm_pkg::t_back_state        r_state;
    swrm_pkg::t_back_state        n_state;
    swrm_pkg::t_item              r_item;
    logic [swrm_pkg::PTR_W-1:0]   r_oldest_ptr;
    logic [swrm_pkg::FILL_W-1:0]  r_fill;
    logic [swrm_pkg::SUM_W-1:0]   r_byte_sum;
    logic [swrm_pkg::TIME_W-1:0]  r_oldest_time;
    logic [swrm_pkg::RATE_W-1:0]  r_rate;
    logic                         r_upd;
    logic [swrm_pkg::DVD_W-1:0]   r_dividend;
    logic [swrm_pkg::TIME_W-1:0]  r_span;
    logic                         r_out_valid;
    logic [swrm_pkg::RATE_W-1:0]  r_out_rate;
    logic                         r_out_upd;
    logic [swrm_pkg::FILL_W-1:0]  r_out_fill;

    logic                         full;
    logic                         out_free;
    logic                         ram_we;
    logic [swrm_pkg::PTR_W-1:0]   ram_waddr;
    logic [swrm_pkg::PTR_W-1:0]   rd_ptr;
    logic [swrm_pkg::TIME_W-1:0]  time_rd;
    logic [swrm_pkg::SIZE_W-1:0]  size_rd;
    logic                         div_start;
    logic                         div_done;
    logic [swrm_pkg::DVD_W-1:0]   div_q;
    logic [swrm_pkg::SAT_W-1:0]   q_ext;
    logic [swrm_pkg::RATE_W-1:0]  rate_sat;

    assign full     = (r_fill == swrm_pkg::FILL_W'(swrm_pkg::WINDOW));
    assign out_free = !r_out_valid || !i_stall;
    assign rd_ptr   = swrm_pkg::slot_add(r_oldest_ptr, swrm_pkg::FILL_W'(1));

    assign q_ext    = swrm_pkg::SAT_W'(div_q);
    assign rate_sat = (q_ext > swrm_pkg::SAT_W'(swrm_pkg::RATE_MAX)) ?
                      swrm_pkg::RATE_MAX : swrm_pkg::RATE_W'(q_ext);

    swrm_ram #(
        .WIDTH (swrm_pkg::TIME_W),
        .DEPTH (swrm_pkg::WINDOW)
    ) u_time_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.now),
        .i_raddr (rd_ptr),
        .o_rdata (time_rd)
    );

    swrm_ram #(
        .WIDTH (swrm_pkg::SIZE_W),
        .DEPTH (swrm_pkg::WINDOW)
    ) u_size_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.size),
        .i_raddr (rd_ptr),
        .o_rdata (size_rd)
    );

    swrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_oldest_ptr;
        case (r_state)
            swrm_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_state = swrm_pkg::S_APPLY;
                end
            end
            swrm_pkg::S_APPLY: begin
                case (r_item.kind)
                    swrm_pkg::K_FIRST: begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        n_state   = swrm_pkg::S_OUT;
                    end
                    swrm_pkg::K_APPEND: begin
                        if (full) begin
                            n_state = swrm_pkg::S_EVICT;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = swrm_pkg::slot_add(r_oldest_ptr, r_fill);
                            n_state   = swrm_pkg::S_MUL;
                        end
                    end
                    default: begin
                        n_state = swrm_pkg::S_OUT;
                    end
                endcase
            end
            swrm_pkg::S_EVICT: begin
                // new item takes the slot of the evicted oldest entry
                ram_we    = 1'b1;
                ram_waddr = r_oldest_ptr;
                n_state   = swrm_pkg::S_MUL;
            end
            swrm_pkg::S_MUL: begin
                n_state = swrm_pkg::S_DSTART;
            end
            swrm_pkg::S_DSTART: begin
                div_start = 1'b1;
                n_state   = swrm_pkg::S_DWAIT;
            end
            swrm_pkg::S_DWAIT: begin
                if (div_done) begin
                    n_state = swrm_pkg::S_OUT;
                end
            end
            swrm_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = swrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swrm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest_ptr <= '0;
            r_fill       <= '0;
            r_byte_sum   <= '0;
            r_rate       <= '0;
            r_upd        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                swrm_pkg::S_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                    end
                end
                swrm_pkg::S_APPLY: begin
                    case (r_item.kind)
                        swrm_pkg::K_FIRST: begin
                            r_oldest_ptr  <= '0;
                            r_fill        <= swrm_pkg::FILL_W'(1);
                            r_byte_sum    <= '0;
                            r_oldest_time <= r_item.now;
                            r_upd         <= 1'b0;
                        end
                        swrm_pkg::K_APPEND: begin
                            r_upd <= 1'b1;
                            if (!full) begin
                                r_fill     <= r_fill + 1'b1;
                                r_byte_sum <= r_byte_sum + swrm_pkg::SUM_W'(r_item.size);
                            end
                        end
                        default: begin
                            r_upd <= 1'b0;
                        end
                    endcase
                end
                swrm_pkg::S_EVICT: begin
                    // drop the size of the entry that becomes the new oldest
                    r_oldest_ptr  <= rd_ptr;
                    r_oldest_time <= time_rd;
                    r_byte_sum    <= r_byte_sum - swrm_pkg::SUM_W'(size_rd)
                                     + swrm_pkg::SUM_W'(r_item.size);
                end
                swrm_pkg::S_MUL: begin
                    r_dividend <= swrm_pkg::DVD_W'(r_byte_sum)
                                  * swrm_pkg::DVD_W'(swrm_pkg::BITS_NS_SCALE);
                    r_span     <= r_item.now - r_oldest_time;
                end
                swrm_pkg::S_DWAIT: begin
                    if (div_done) begin
                        r_rate <= rate_sat;
                    end
                end
                swrm_pkg::S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_rate  <= r_rate;
                        r_out_upd   <= r_upd;
                        r_out_fill  <= r_fill;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rate_bps     = r_out_rate;
    assign o_rate_updated = r_out_upd;
    assign o_window_fill  = r_out_fill;

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == swrm_pkg::S_EVICT |-> full)
        else $error("eviction with a window that is not full");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= swrm_pkg::FILL_W'(swrm_pkg::WINDOW))
        else $error("window fill beyond window size");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == swrm_pkg::S_DWAIT)
        else $error("divider finished outside the wait state");

    a_pop_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == swrm_pkg::S_APPLY)
        else $error("popped item not applied");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swrm_pkg::S_OUT && out_free) |=> r_out_valid)
        else $error("result not presented after output load");

endmodule

FILE: test/sliding_window_rate_meter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_test - self-checking bench for the rate meter
// Feeds packet events through a stall/valid driver and checks every result
// against an in-bench window model, across several size offset settings,
// random idling on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_test;

    localparam int TIME_W = swrm_pkg::TIME_W;
    localparam int PKT_W  = swrm_pkg::PKT_W;
    localparam int OFS_W  = swrm_pkg::OFS_W;
    localparam int SIZE_W = swrm_pkg::SIZE_W;
    localparam int RATE_W = swrm_pkg::RATE_W;
    localparam int FILL_W = swrm_pkg::FILL_W;
    localparam int PTR_W  = swrm_pkg::PTR_W;
    localparam int SUM_W  = swrm_pkg::SUM_W;
    localparam int WINDOW = swrm_pkg::WINDOW;

    localparam logic [TIME_W-1:0] TIME_TOP        = '1;
    localparam logic [RATE_W-1:0] RATE_TOP        = '1;
    localparam logic [63:0]       BITS_PER_NS_SEC = 64'd8_000_000_000;
    localparam logic [63:0]       TIME_RESERVE    = 64'd1 << 24;
    localparam int                PHASES          = 5;
    localparam int                PHASE_ITEMS     = 336;
    localparam int                HOLD_CYCLES     = 600;
    localparam int                WATCHDOG_LIMIT  = 5000;

    typedef struct {
        logic [TIME_W-1:0] now;
        logic [PKT_W-1:0]  pkt;
    } t_packet_event;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic              updated;
        logic [FILL_W-1:0] fill;
    } t_meter_reading;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic [TIME_W-1:0]   i_now_ns       = '0;
    logic [PKT_W-1:0]    i_pkt_size     = '0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic [RATE_W-1:0]   o_rate_bps;
    logic                o_rate_updated;
    logic [FILL_W-1:0]   o_window_fill;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [OFS_W-1:0]    i_cfg_data     = '0;

    sliding_window_rate_meter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_now_ns       (i_now_ns),
        .i_pkt_size     (i_pkt_size),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rate_bps     (o_rate_bps),
        .o_rate_updated (o_rate_updated),
        .o_window_fill  (o_window_fill),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // window model state
    logic [TIME_W-1:0] win_time [WINDOW];
    logic [SIZE_W-1:0] win_size [WINDOW];
    logic [PTR_W-1:0]  win_head   = '0;
    logic [FILL_W-1:0] win_fill   = '0;
    logic [SUM_W-1:0]  win_bytes  = '0;
    logic [RATE_W-1:0] held_rate  = '0;
    logic [OFS_W-1:0]  cur_offset = '0;

    t_packet_event  pending_items [$];
    t_meter_reading readings_due  [$];

    logic [TIME_W-1:0] gen_time    = '0;
    logic              gen_started = 1'b0;

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int appends        = 0;
    int ignored        = 0;
    int evictions      = 0;
    int cfg_writes     = 0;
    int src_wait       = 0;
    int sink_wait      = 0;
    int idle_cycles    = 0;
    bit src_steady     = 1'b0;
    bit sink_steady    = 1'b0;

    function automatic logic [PTR_W-1:0] ring_at(input int k);
        return PTR_W'((int'(win_head) + k) % WINDOW);
    endfunction

    function automatic t_meter_reading meter_advance(input logic [TIME_W-1:0] now,
                                                     input logic [PKT_W-1:0]  pkt);
        t_meter_reading    rd;
        logic [SIZE_W-1:0] bytes;
        logic [PTR_W-1:0]  wr_at;
        logic [TIME_W-1:0] span;
        logic [63:0]       quot;
        bytes      = SIZE_W'(pkt) + SIZE_W'(cur_offset);
        rd.updated = 1'b0;
        if (win_fill == '0) begin
            win_head    = '0;
            win_time[0] = now;
            win_size[0] = bytes;
            win_fill    = FILL_W'(1);
            win_bytes   = '0;
        end else if (now > win_time[ring_at(int'(win_fill) - 1)]) begin
            // drop the oldest; the new oldest leaves the byte sum
            if (win_fill == FILL_W'(WINDOW)) begin
                win_head  = ring_at(1);
                win_fill  = FILL_W'(WINDOW - 1);
                win_bytes = win_bytes - SUM_W'(win_size[win_head]);
                evictions++;
            end
            wr_at           = ring_at(int'(win_fill));
            win_time[wr_at] = now;
            win_size[wr_at] = bytes;
            win_fill        = win_fill + 1'b1;
            win_bytes       = win_bytes + SUM_W'(bytes);
            span            = now - win_time[win_head];
            if (span != '0) begin
                quot      = (64'(win_bytes) * BITS_PER_NS_SEC) / 64'(span);
                held_rate = (quot > 64'(RATE_TOP)) ? RATE_TOP : RATE_W'(quot);
            end
            rd.updated = 1'b1;
            appends++;
        end else begin
            ignored++;
        end
        rd.rate = held_rate;
        rd.fill = win_fill;
        return rd;
    endfunction

    // driver: one item in flight on the input channel
    always @(posedge i_clk) begin
        t_packet_event ev;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                readings_due.push_back(meter_advance(i_now_ns, i_pkt_size));
                items_accepted++;
                if (items_accepted % 100 == 0) begin
                    src_steady = ($urandom_range(0, 3) == 0);
                end
                src_wait = src_steady ? 0 : $urandom_range(0, 7);
            end
            // hold a stalled item; otherwise load the next one or idle
            if (!i_valid || !o_stall) begin
                if (src_wait == 0 && pending_items.size() != 0) begin
                    ev = pending_items.pop_front();
                    i_valid    <= 1'b1;
                    i_now_ns   <= ev.now;
                    i_pkt_size <= ev.pkt;
                end else begin
                    if (src_wait > 0) begin
                        src_wait--;
                    end
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results and pace the receiver
    always @(posedge i_clk) begin
        t_meter_reading want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: rate %0d updated %0b fill %0d",
                                 o_rate_bps, o_rate_updated, o_window_fill);
                    end
                end else begin
                    want = readings_due.pop_front();
                    if (o_rate_bps !== want.rate || o_rate_updated !== want.updated ||
                        o_window_fill !== want.fill) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected rate %0d updated %0b fill %0d",
                                     results_seen, want.rate, want.updated, want.fill);
                            $display("result %0d:      got rate %0d updated %0b fill %0d",
                                     results_seen, o_rate_bps, o_rate_updated,
                                     o_window_fill);
                        end
                    end
                end
                if (results_seen % 100 == 0) begin
                    sink_steady = ($urandom_range(0, 3) == 0);
                end
                // long hold-off lets the block back up into its input
                if (results_seen == 400 || results_seen == 1100) begin
                    sink_wait = HOLD_CYCLES;
                end else begin
                    sink_wait = sink_steady ? 0 : $urandom_range(0, 7);
                end
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            i_stall <= (sink_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles, %0d of %0d results",
                     idle_cycles, results_seen, items_queued);
            $display("sliding_window_rate_meter test failed");
            $finish;
        end
    end

    task automatic queue_item(input logic [TIME_W-1:0] now, input logic [PKT_W-1:0] pkt);
        t_packet_event ev;
        ev.now = now;
        ev.pkt = pkt;
        pending_items.push_back(ev);
        items_queued++;
        if (!gen_started || now > gen_time) begin
            gen_time    = now;
            gen_started = 1'b1;
        end
    endtask

    task automatic drain(input int settle);
        while (results_seen < items_queued) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic offset_write(input logic [OFS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_offset = value;
        cfg_writes++;
    endtask

    task automatic queue_random_phase(input int count);
        logic [TIME_W-1:0] t;
        logic [63:0]       r;
        logic [63:0]       delta;
        logic [PKT_W-1:0]  pkt;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            r    = {$urandom, $urandom};
            if (pick < 6) begin
                t = gen_time;
            end else if (pick < 12) begin
                t = TIME_W'(r % (64'(gen_time) + 64'd1));
            end else begin
                if (pick < 20) begin
                    delta = 64'd1;
                end else if (pick < 80) begin
                    delta = 64'($urandom_range(1, 5000));
                end else if (pick < 97) begin
                    delta = 64'($urandom_range(1, 32'h00FF_FFFF));
                end else begin
                    delta = (r & 64'hFFFF_FFFF_FFFF) >> $urandom_range(6, 20);
                end
                // keep room for the closing top-of-range timestamp
                if (delta == 0 || 64'(gen_time) + delta > 64'(TIME_TOP) - TIME_RESERVE) begin
                    delta = 64'd1;
                end
                t = gen_time + TIME_W'(delta);
            end
            case ($urandom_range(0, 9))
                0:       pkt = '0;
                1:       pkt = '1;
                2:       pkt = PKT_W'($urandom_range(0, 64));
                default: pkt = PKT_W'($urandom);
            endcase
            queue_item(t, pkt);
        end
    endtask

    initial begin
        logic [OFS_W-1:0] ofs;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first event, repeats, zero byte sum, backward time, minimum time step
        queue_item(48'd0, 16'd0);
        queue_item(48'd0, 16'hFFFF);
        queue_item(48'd5, 16'd0);
        queue_item(48'd6, 16'hFFFF);
        queue_item(48'd6, 16'd0);
        queue_item(48'd3, 16'd1);
        queue_item(48'd7, 16'hFFFF);
        queue_item(48'd7 + (48'd1 << 40), 16'd64);
        drain(8);

        offset_write('1);
        for (int n = 0; n < 8; n++) begin
            queue_item(gen_time + 48'd1, (n % 2 == 0) ? 16'hFFFF : 16'd0);
        end
        drain(8);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       ofs = '0;
                2:       ofs = '1;
                default: ofs = OFS_W'($urandom_range(1, 254));
            endcase
            offset_write(ofs);
            queue_random_phase(PHASE_ITEMS);
            drain(8);
        end

        // top of the time range, then nothing can advance
        queue_item(TIME_TOP, 16'hFFFF);
        queue_item(TIME_TOP, 16'd0);
        queue_item(48'd0, 16'd0);
        queue_item(TIME_W'({$urandom, $urandom}), PKT_W'($urandom));
        drain(70);

        $display("%0d packet events: %0d appended, %0d ignored, %0d evicted an entry",
                 items_accepted, appends, ignored, evictions);
        $display("%0d results checked over %0d size offset settings, %0d mismatches",
                 results_seen, cfg_writes + 1, mismatches);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("sliding_window_rate_meter test passed");
        end else begin
            $display("sliding_window_rate_meter test failed");
        end
        $finish;
    end

endmodule
